### rtl/fmi_pkg.sv
// ----------------------------------------------------------------------------
// fmi_pkg
// Types, constants and modular helpers for the Fermat modular inverse block.
// ----------------------------------------------------------------------------
package fmi_pkg;

    localparam int MOD_BITS = 31;
    localparam int CNT_W    = $clog2(MOD_BITS);

    typedef logic [MOD_BITS-1:0] word_t;
    typedef logic [MOD_BITS:0]   wide_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    localparam word_t MOD_RESET = word_t'(2);
    localparam word_t TWO       = word_t'(2);
    localparam cnt_t  LAST_BIT  = cnt_t'(MOD_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL,
        ST_DONE
    } state_t;

    // (x + y) mod m for x, y < m
    function automatic word_t add_mod(input word_t x, input word_t y, input word_t m);
        wide_t s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[MOD_BITS-1:0];
    endfunction

    // one restoring-division step: (2*r + b) mod m for r < m
    function automatic word_t rem_step(input word_t r, input logic b, input word_t m);
        wide_t s;
        s = {r, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[MOD_BITS-1:0];
    endfunction

endpackage

### rtl/fmi_if.sv
// ----------------------------------------------------------------------------
// fmi_if
// Valid/ready channels of the Fermat modular inverse block.
// ----------------------------------------------------------------------------
interface fmi_in_if;
    logic                  valid;
    logic                  ready;
    logic [fmi_pkg::MOD_BITS-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface fmi_out_if;
    logic                  valid;
    logic                  ready;
    logic [fmi_pkg::MOD_BITS-1:0] inverse_value;
    logic                  no_inverse;
    modport source (output valid, output inverse_value, output no_inverse, input ready);
    modport sink   (input valid, input inverse_value, input no_inverse, output ready);
endinterface

interface fmi_cfg_if;
    logic                  valid;
    logic                  ready;
    logic [fmi_pkg::MOD_BITS-1:0] modulus;
    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

### rtl/fermat_modular_inverse.sv
// ----------------------------------------------------------------------------
// fermat_modular_inverse
// A value of 0 or a modulus below two skips straight to the result (0); any
// other value is reduced mod the modulus bit by bit, then raised to modulus-2.
// One word at a time: a new word is taken only in idle. The bit-serial modular
// multiplier forms result*base and base*base together, one multiplier bit a cycle.
// Reset: modulus returns to 2, the controller idles, no result is pending.
// ----------------------------------------------------------------------------
module fermat_modular_inverse (
    input  logic  clk,
    input  logic  rst_n,
    fmi_cfg_if.sink   cfg,
    fmi_in_if.sink    operand,
    fmi_out_if.source result
);
    import fmi_pkg::*;

    state_t state_reg, state_next;

    word_t modulus_reg;
    word_t vsh_reg;
    word_t rem_reg;
    word_t res_reg;
    word_t base_reg;
    word_t exp_reg;
    word_t x1_reg, x2_reg;
    word_t acc1_reg, acc2_reg;
    cnt_t  cnt_reg;
    logic  flag_reg;

    word_t out_val_reg;
    logic  out_flag_reg;
    logic  out_valid_reg;

    logic  accept;
    logic  trivial;
    logic  out_load;
    logic  out_free;

    assign cfg.ready = 1'b1;
    assign result.valid         = out_valid_reg;
    assign result.inverse_value = out_val_reg;
    assign result.no_inverse    = out_flag_reg;

    assign out_free = !out_valid_reg || result.ready;
    assign trivial  = (operand.value == '0) || (modulus_reg < TWO);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (operand.valid)
                begin
                    state_next = trivial ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (cnt_reg == LAST_BIT)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = (exp_reg == '0) ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == LAST_BIT)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        operand.ready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: operand.ready = 1'b1;
            ST_DONE: out_load      = out_free;
            default:
            begin
                operand.ready = 1'b0;
                out_load      = 1'b0;
            end
        endcase
    end

    assign accept = operand.valid && operand.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= MOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                modulus_reg <= cfg.modulus;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    vsh_reg  <= operand.value;
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                    flag_reg <= (operand.value == '0);
                    res_reg  <= trivial ? word_t'(0) : word_t'(1);
                end
            end
            ST_REDUCE:
            begin
                // shift the value in MSB first, keep the remainder below m
                rem_reg <= rem_step(rem_reg, vsh_reg[MOD_BITS-1], modulus_reg);
                vsh_reg <= {vsh_reg[MOD_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + cnt_t'(1);
                if (cnt_reg == LAST_BIT)
                begin
                    base_reg <= rem_step(rem_reg, vsh_reg[MOD_BITS-1], modulus_reg);
                    exp_reg  <= modulus_reg - TWO;
                end
            end
            ST_STEP:
            begin
                x1_reg   <= res_reg;
                x2_reg   <= base_reg;
                acc1_reg <= '0;
                acc2_reg <= '0;
                cnt_reg  <= '0;
            end
            ST_MUL:
            begin
                // both products share the multiplier bits of base
                if (base_reg[cnt_reg])
                begin
                    acc1_reg <= add_mod(acc1_reg, x1_reg, modulus_reg);
                    acc2_reg <= add_mod(acc2_reg, x2_reg, modulus_reg);
                end
                x1_reg  <= add_mod(x1_reg, x1_reg, modulus_reg);
                x2_reg  <= add_mod(x2_reg, x2_reg, modulus_reg);
                cnt_reg <= cnt_reg + cnt_t'(1);
                if (cnt_reg == LAST_BIT)
                begin
                    if (exp_reg[0])
                    begin
                        res_reg <= base_reg[cnt_reg]
                                   ? add_mod(acc1_reg, x1_reg, modulus_reg) : acc1_reg;
                    end
                    base_reg <= base_reg[cnt_reg]
                                ? add_mod(acc2_reg, x2_reg, modulus_reg) : acc2_reg;
                    exp_reg  <= exp_reg >> 1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_val_reg  <= res_reg;
                    out_flag_reg <= flag_reg;
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && flag_reg |-> res_reg == '0)
        else $error("flagged result is not zero");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !operand.ready)
        else $error("operand accepted while busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg || result.ready)
        else $error("pending result overwritten");

endmodule

### verif/tb_fermat_modular_inverse.sv
// ----------------------------------------------------------------------------
// tb_fermat_modular_inverse
// Self-checking bench for the Fermat modular inverse block. Words are
// predicted by a square-and-multiply model at acceptance and compared with
// each result in order. The run is split into phases. Each phase sets a
// modulus (prime, composite, the extremes 0, 1, 2 and 2^31-1) and uses one of
// four idling patterns on the operand and result channels.
// ----------------------------------------------------------------------------
module tb_fermat_modular_inverse;
    timeunit 1ns;
    timeprecision 1ps;

    import fmi_pkg::*;

    typedef struct packed {
        word_t inv;
        logic  flag;
    } inverse_t;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;
    localparam int HOLD_PHASE = 7;
    localparam int HOLD_CYCLES = 1500;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fmi_cfg_if cfg ();
    fmi_in_if  operand ();
    fmi_out_if result ();

    fermat_modular_inverse uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .operand (operand),
        .result  (result)
    );

    word_t    pending_values[$];
    inverse_t expected_inverses[$];
    word_t    cur_modulus = MOD_RESET;
    int       idle_mode = IDLE_NONE;
    int       hold_left = 0;
    logic     hold_done = 1'b0;
    int       errors = 0;
    int       words_in = 0;
    int       words_out = 0;
    int       flagged = 0;
    int       phases = 0;

    always #2 clk = ~clk;

    // value^(m-2) mod m by right-to-left square-and-multiply
    function automatic inverse_t predict_inverse(input word_t v, input word_t m);
        inverse_t         r;
        longint unsigned  base;
        longint unsigned  acc;
        longint unsigned  e;
        r.flag = (v == 0);
        r.inv  = '0;
        if (!r.flag && m >= 2)
        begin
            base = longint'(v) % longint'(m);
            e    = longint'(m) - 2;
            acc  = 1;
            while (e != 0)
            begin
                if (e[0])
                begin
                    acc = (acc * base) % m;
                end
                base = (base * base) % m;
                e = e >> 1;
            end
            r.inv = word_t'(acc % m);
        end
        return r;
    endfunction

    // driver: record the accepted word, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand.valid <= 1'b0;
            operand.value <= '0;
        end
        else
        begin
            if (operand.valid && operand.ready)
            begin
                expected_inverses = {expected_inverses,
                                     predict_inverse(operand.value, cur_modulus)};
                words_in++;
            end
            if (!operand.valid || operand.ready)
            begin
                if (pending_values.size() > 0 &&
                    !((idle_mode == IDLE_SEND && $urandom_range(99) < 55) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 19)))
                begin
                    operand.valid <= 1'b1;
                    operand.value <= pending_values.pop_front();
                end
                else
                begin
                    operand.valid <= 1'b0;
                end
            end
        end
    end

    // hold counter: stall the result side for a long stretch once
    always @(posedge clk)
    begin
        if (phases == HOLD_PHASE && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: check each result word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        inverse_t exp_w;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                words_out++;
                if (expected_inverses.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word inverse=%0d flag=%0b", $time,
                             result.inverse_value, result.no_inverse);
                end
                else
                begin
                    exp_w = expected_inverses.pop_front();
                    if (exp_w.flag)
                    begin
                        flagged++;
                    end
                    if (result.inverse_value !== exp_w.inv)
                    begin
                        errors++;
                        $display("%0t: inverse_value expected %0d actual %0d", $time,
                                 exp_w.inv, result.inverse_value);
                    end
                    if (result.no_inverse !== exp_w.flag)
                    begin
                        errors++;
                        $display("%0t: no_inverse expected %0b actual %0b", $time,
                                 exp_w.flag, result.no_inverse);
                    end
                end
            end
            if (hold_left > 0)
            begin
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 55) ||
                                  (idle_mode == IDLE_BOTH && $urandom_range(99) < 19));
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic wait_drained();
        @(posedge clk);
        while (pending_values.size() > 0 || operand.valid || expected_inverses.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_modulus(input word_t m);
        cfg.valid   <= 1'b1;
        cfg.modulus <= m;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid   <= 1'b0;
        cur_modulus = m;
        phases++;
    endtask

    function automatic word_t pick_value(input word_t m);
        int unsigned sel;
        word_t       v;
        sel = $urandom_range(99);
        if (sel < 5)
        begin
            v = '0;
        end
        else if (sel < 10)
        begin
            v = word_t'($urandom);
        end
        else if (sel < 14 && m >= 1)
        begin
            v = word_t'(m * $urandom_range(1, 5));
        end
        else if (sel < 16)
        begin
            v = {MOD_BITS{1'b1}};
        end
        else if (m >= 2)
        begin
            v = word_t'($urandom_range(m - 1, 1));
        end
        else
        begin
            v = word_t'($urandom_range(1000, 1));
        end
        return v;
    endfunction

    initial
    begin
        int unsigned primes[];
        int unsigned big_primes[];
        word_t       m;
        int          n;
        int          sel;
        int          target;

        primes = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
                   47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101,
                   127, 131, 163, 197, 211, 241, 251};
        big_primes = '{2147483647, 2147483629, 1000000007, 998244353};
        cfg.valid = 1'b0;
        cfg.modulus = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: largest prime, zero, multiples of the modulus
        write_modulus(word_t'(2147483647));
        pending_values = '{0, 1, 2, 3, 31'h7FFF_FFFE, 31'h7FFF_FFFF, 31'h4000_0000};
        wait_drained();
        // modulus two: every nonzero value gives 1
        write_modulus(TWO);
        pending_values = '{0, 1, 6, 31'h7FFF_FFFF};
        wait_drained();
        // modulus below two: no inverse defined
        write_modulus(word_t'(0));
        pending_values = '{0, 7, 31'h5555_5555};
        wait_drained();
        write_modulus(word_t'(1));
        pending_values = '{0, 9};
        wait_drained();
        // composite modulus
        write_modulus(word_t'(15));
        pending_values = '{2, 3, 14, 31'h2AAA_AAAA};
        wait_drained();

        target = words_in + 1430;
        while (words_in < target)
        begin
            sel = $urandom_range(99);
            n = 50;
            if (sel < 68)
            begin
                m = word_t'(primes[$urandom_range(primes.size() - 1)]);
            end
            else if (sel < 80)
            begin
                m = word_t'($urandom_range(1000, 4));
            end
            else if (sel < 90)
            begin
                m = word_t'($urandom_range(3));
            end
            else
            begin
                m = word_t'(big_primes[$urandom_range(big_primes.size() - 1)]);
                n = 8;
            end
            if (n > target - words_in)
            begin
                n = target - words_in;
            end
            idle_mode = phases % 4;
            write_modulus(m);
            // long hold on the result side while words keep coming
            if (phases == HOLD_PHASE)
            begin
                idle_mode = IDLE_NONE;
            end
            repeat (n) pending_values = {pending_values, pick_value(m)};
            wait_drained();
        end

        $display("Covered %0d words over %0d modulus settings, %0d of them zero-valued.",
                 words_in, phases, flagged);
        $display("Checked %0d result words under four idling patterns.", words_out);
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
